// ===== hdl/rcd_pkg.sv =====
// Shared codes and the controller/datapath command type for the restricted circular deque.
package rcd_pkg;

    // Request codes
    localparam logic [1:0] REQ_PUSH_BACK  = 2'd0;
    localparam logic [1:0] REQ_PUSH_FRONT = 2'd1;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [1:0] REQ_POP_BACK   = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [1:0] STAT_REFUSED   = 2'd3;

    // Restriction modes
    localparam logic MODE_IN_RESTRICTED  = 1'b0;
    localparam logic MODE_OUT_RESTRICTED = 1'b1;

    localparam int POP_WIDTH  = 32;
    localparam int FILL_WIDTH = 5;

    typedef struct packed {
        logic exec;   // apply the presented item to state and memory
        logic load;   // capture the result into the output register
    } t_dp_cmd;

endpackage

// ===== hdl/restricted_circular_deque_core.sv =====
// Restricted circular deque core: top level joining controller and datapath.
// Result path: the accepted item's ring-memory read is registered, then loaded into the output register.
// A new item is taken only after the previous result has been taken; set by the registered
//   ring-memory read and the single result register that holds until taken.
// Reset (synchronous, active low): deque empty, indices zero, mode input-restricted.
// Ring contents are not cleared; a read value is only returned for an entry that has been written.
module restricted_circular_deque_core #(
    parameter int RING_DEPTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_push_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pop_value,
    output logic [1:0]         o_status,
    output logic [4:0]         o_fill_count,
    // mode register write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    rcd_pkg::t_dp_cmd cmd;

    // Mode register accepts writes at any time; user must write it only while idle (not enforced).
    assign o_cfg_ready = 1'b1;

    // Controller: accepts an item only in idle, then walks read and delivery.
    rcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Datapath: status decode, index update, ring write/read, result register.
    rcd_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_req_type   (i_req_type),
        .i_push_value (i_push_value),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_fill_count (o_fill_count)
    );

`ifndef SYNTHESIS
    // No new item while a result is pending
    a_no_accept_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("item accepted while result pending");

    // Result shows after accept, once the LOAD state has passed
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !o_out_valid ##1 o_out_valid)
        else $error("result latency broken");

    // Overflow only reported with a full ring
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == rcd_pkg::STAT_OVERFLOW))
            |-> (o_fill_count == 5'(RING_DEPTH)))
        else $error("overflow with ring not full");

    // Underflow only from an empty deque, and returns zero
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == rcd_pkg::STAT_UNDERFLOW))
            |-> ((o_fill_count == '0) && (o_pop_value == '0)))
        else $error("underflow with elements held");
`endif

endmodule

// ===== hdl/rcd_ctrl.sv =====
// Handshake controller: sequences accept, memory read and result delivery.
module rcd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output rcd_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_SEND = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (!i_out_stall) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_SEND);
    assign o_cmd.exec  = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.load  = (r_state == ST_LOAD);

endmodule

// ===== hdl/rcd_datapath.sv =====
// Deque datapath: ring memory, front/back indices, element count, mode register.
module rcd_datapath #(
    parameter int RING_DEPTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rcd_pkg::t_dp_cmd                     i_cmd,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_data,
    input  logic [1:0]                           i_req_type,
    input  logic signed [31:0]                   i_push_value,
    output logic signed [rcd_pkg::POP_WIDTH-1:0] o_pop_value,
    output logic [1:0]                           o_status,
    output logic [rcd_pkg::FILL_WIDTH-1:0]       o_fill_count
);

    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(RING_DEPTH);

    logic [DATA_WIDTH-1:0] mem [RING_DEPTH];

    logic [IW-1:0]         r_front, n_front;
    logic [IW-1:0]         r_back, n_back;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_mode;
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_pop_ok;
    logic [1:0]            r_status;
    logic signed [rcd_pkg::POP_WIDTH-1:0] r_pop_value;

    logic            is_push, refused, do_push, do_pop;
    logic [1:0]      stat;
    logic [IW-1:0]   slot;

    function automatic logic [IW-1:0] step_up(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IW-1:0] step_down(input logic [IW-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    always_comb begin
        is_push = (i_req_type == rcd_pkg::REQ_PUSH_BACK) ||
                  (i_req_type == rcd_pkg::REQ_PUSH_FRONT);
        refused = ((i_req_type == rcd_pkg::REQ_PUSH_FRONT) &&
                   (r_mode == rcd_pkg::MODE_IN_RESTRICTED)) ||
                  ((i_req_type == rcd_pkg::REQ_POP_BACK) &&
                   (r_mode == rcd_pkg::MODE_OUT_RESTRICTED));
        do_push = 1'b0;
        do_pop  = 1'b0;
        priority if (refused) begin
            stat = rcd_pkg::STAT_REFUSED;
        end else if (is_push && (r_count >= FULL_CNT)) begin
            stat = rcd_pkg::STAT_OVERFLOW;
        end else if (!is_push && (r_count == '0)) begin
            stat = rcd_pkg::STAT_UNDERFLOW;
        end else begin
            stat    = rcd_pkg::STAT_OK;
            do_push = is_push;
            do_pop  = !is_push;
        end

        n_front = r_front;
        n_back  = r_back;
        n_count = r_count;
        slot    = (i_req_type == rcd_pkg::REQ_POP_BACK) ? r_back : r_front;
        if (do_push) begin
            n_count = r_count + 1'b1;
            priority if (r_count == '0) begin
                n_front = '0;
                n_back  = '0;
                slot    = '0;
            end else if (i_req_type == rcd_pkg::REQ_PUSH_BACK) begin
                n_back = step_up(r_back);
                slot   = n_back;
            end else begin
                n_front = step_down(r_front);
                slot    = n_front;
            end
        end else if (do_pop) begin
            n_count = r_count - 1'b1;
            priority if (r_count == CW'(1)) begin
                n_front = '0;
                n_back  = '0;
            end else if (i_req_type == rcd_pkg::REQ_POP_FRONT) begin
                n_front = step_up(r_front);
            end else begin
                n_back = step_down(r_back);
            end
        end
    end

    // Ring memory: one registered read per item, plus one write for an accepted push
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (do_push) mem[slot] <= DATA_WIDTH'(i_push_value);
            r_rd_data <= mem[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
            r_mode  <= rcd_pkg::MODE_IN_RESTRICTED;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_data;
            if (i_cmd.exec) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_pop_ok <= do_pop;
            r_status <= stat;
        end
        if (i_cmd.load) begin
            r_pop_value <= r_pop_ok ?
                rcd_pkg::POP_WIDTH'($signed(r_rd_data)) : '0;
        end
    end

    assign o_pop_value  = r_pop_value;
    assign o_status     = r_status;
    assign o_fill_count = rcd_pkg::FILL_WIDTH'(r_count);

endmodule
